// ----- rtl/jsu_pkg.sv -----
// shared types, character codes and helper functions of the json string unescape unit
package jsu_pkg;

  // how a decoded string ended
  typedef enum logic [1:0] {
    OUT_ONGOING  = 2'd0,
    OUT_CLOSED   = 2'd1,
    OUT_EARLY    = 2'd2,
    OUT_NO_QUOTE = 2'd3
  } outcome_e;

  localparam logic [7:0] CHAR_QUOTE     = 8'h22;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_N         = 8'h6E;
  localparam logic [7:0] CHAR_R         = 8'h72;
  localparam logic [7:0] CHAR_T         = 8'h74;
  localparam logic [7:0] CHAR_B         = 8'h62;
  localparam logic [7:0] CHAR_F         = 8'h66;
  localparam logic [7:0] CHAR_U         = 8'h75;

  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_HT = 8'h09;
  localparam logic [7:0] BYTE_BS = 8'h08;
  localparam logic [7:0] BYTE_FF = 8'h0C;

  localparam logic [15:0] UTF8_LIMIT1 = 16'h0080;
  localparam logic [15:0] UTF8_LIMIT2 = 16'h0800;
  localparam logic [7:0]  UTF8_CONT   = 8'h80;
  localparam logic [7:0]  UTF8_LEAD2  = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3  = 8'hE0;
  localparam logic [7:0]  UTF8_LOW6   = 8'h3F;

  // up to three bytes produced by one input word
  typedef struct packed {
    logic [1:0]      count;
    logic [2:0][7:0] bytes;
    logic            byte_valid;
    logic            done;
    outcome_e        outcome;
  } group_t;

  typedef struct packed {
    logic [1:0]      count;
    logic [2:0][7:0] bytes;
  } utf8_t;

  // non-hex digits count as zero
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
    return v[3:0];
  endfunction

  // single character escapes, anything else passes through
  function automatic logic [7:0] escape_byte(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c == CHAR_N) r = BYTE_LF;
    else if (c == CHAR_R) r = BYTE_CR;
    else if (c == CHAR_T) r = BYTE_HT;
    else if (c == CHAR_B) r = BYTE_BS;
    else if (c == CHAR_F) r = BYTE_FF;
    return r;
  endfunction

  // bytes in emission order, first byte in bytes[0]
  function automatic utf8_t utf8_encode(input logic [15:0] cp);
    utf8_t e;
    e = '0;
    if (cp < UTF8_LIMIT1) begin
      e.count    = 2'd1;
      e.bytes[0] = cp[7:0];
    end else if (cp < UTF8_LIMIT2) begin
      e.count    = 2'd2;
      e.bytes[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
      e.bytes[1] = UTF8_CONT | ({2'b00, cp[5:0]} & UTF8_LOW6);
    end else begin
      e.count    = 2'd3;
      e.bytes[0] = UTF8_LEAD3 | {4'b0000, cp[15:12]};
      e.bytes[1] = UTF8_CONT | ({2'b00, cp[11:6]} & UTF8_LOW6);
      e.bytes[2] = UTF8_CONT | ({2'b00, cp[5:0]} & UTF8_LOW6);
    end
    return e;
  endfunction

endpackage

// ----- rtl/json_string_unescape_unit.sv -----
// top level of the json string unescape unit: decoder and result queue
// latency: first result word of an input word is shown the cycle after it is taken,
//   when the queue holds nothing older
// throughput: one input word per cycle while the queue is not full; an input word yielding k
//   bytes gives k output words, and a queue of FifoDepth groups absorbs the utf-8 bursts
// input stall rises only when the result queue is full
// reset (asynchronous, active low) returns to awaiting the opening quote, queue empty
module json_string_unescape_unit import jsu_pkg::*; #(
  parameter int FifoDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  input  logic       text_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       run_last_o,
  output logic       string_done_o,
  output logic [1:0] outcome_o
);

  localparam int AW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int CW = $clog2(FifoDepth + 1);
  localparam logic [CW-1:0] QueueFull = CW'(FifoDepth);
  localparam logic [AW-1:0] LastSlot  = AW'(FifoDepth - 1);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_STR,
    MODE_ESC,
    MODE_DONE
  } mode_e;

  // decoder state
  mode_e       mode_q, mode_d;
  logic        in_hex_q, in_hex_d;
  logic [1:0]  seen_q, seen_d;
  logic [15:0] cp_q, cp_d;

  // result queue, one group per input word that yields bytes or ends the string
  group_t        fifo_q [FifoDepth];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic [1:0]    sub_q;

  logic        in_acc, out_acc, push, pop;
  group_t      grp, head;
  outcome_e    finish;
  logic [15:0] cp_next;
  utf8_t       enc_cur, enc_next;
  logic        last;

  assign in_stall_o = (count_q == QueueFull);
  assign in_acc     = in_valid_i && !in_stall_o;

  // the partial code point on text end, and the completed one on the fourth digit
  assign cp_next  = {cp_q[11:0], hex_value(text_byte_i)};
  assign enc_cur  = utf8_encode(cp_q);
  assign enc_next = utf8_encode(cp_next);

  always_comb begin
    mode_d   = mode_q;
    in_hex_d = in_hex_q;
    seen_d   = seen_q;
    cp_d     = cp_q;
    grp      = '0;
    finish   = OUT_ONGOING;
    if (in_acc) begin
      unique case (mode_q)
        MODE_IDLE: begin
          if (!text_end_i && text_byte_i == CHAR_QUOTE) mode_d = MODE_STR;
          else finish = OUT_NO_QUOTE;
        end
        MODE_STR: begin
          if (text_end_i) finish = OUT_EARLY;
          else if (text_byte_i == CHAR_QUOTE) finish = OUT_CLOSED;
          else if (text_byte_i == CHAR_BACKSLASH) mode_d = MODE_ESC;
          else begin
            grp.count      = 2'd1;
            grp.bytes[0]   = text_byte_i;
            grp.byte_valid = 1'b1;
          end
        end
        MODE_ESC: begin
          if (in_hex_q) begin
            if (text_end_i) begin
              // flush whatever digits were gathered
              grp.count      = enc_cur.count;
              grp.bytes      = enc_cur.bytes;
              grp.byte_valid = 1'b1;
              finish         = OUT_EARLY;
            end else if (seen_q == 2'd3) begin
              grp.count      = enc_next.count;
              grp.bytes      = enc_next.bytes;
              grp.byte_valid = 1'b1;
              in_hex_d       = 1'b0;
              seen_d         = 2'd0;
              cp_d           = cp_next;
              mode_d         = MODE_STR;
            end else begin
              cp_d   = cp_next;
              seen_d = seen_q + 2'd1;
            end
          end else if (text_end_i) begin
            finish = OUT_EARLY;
          end else if (text_byte_i == CHAR_U) begin
            in_hex_d = 1'b1;
            seen_d   = 2'd0;
            cp_d     = 16'h0000;
          end else begin
            mode_d         = MODE_STR;
            grp.count      = 2'd1;
            grp.bytes[0]   = escape_byte(text_byte_i);
            grp.byte_valid = 1'b1;
          end
        end
        MODE_DONE: begin
          // everything after the end is dropped
        end
        default: begin
          mode_d = MODE_DONE;
        end
      endcase
    end
    if (finish != OUT_ONGOING) begin
      // ending with nothing to show gives one empty result word
      if (grp.count == 2'd0) begin
        grp.count      = 2'd1;
        grp.byte_valid = 1'b0;
      end
      grp.done    = 1'b1;
      grp.outcome = finish;
      mode_d      = MODE_DONE;
      in_hex_d    = 1'b0;
      seen_d      = 2'd0;
      cp_d        = 16'h0000;
    end
  end

  // queue head, one byte of the group per output word
  assign head          = fifo_q[rd_ptr_q];
  assign last          = (sub_q == head.count - 2'd1);
  assign out_valid_o   = (count_q != '0);
  assign out_byte_o    = head.bytes[sub_q];
  assign byte_valid_o  = head.byte_valid;
  assign run_last_o    = last;
  assign string_done_o = last && head.done;
  assign outcome_o     = (last && head.done) ? head.outcome : OUT_ONGOING;

  assign out_acc = out_valid_o && !out_stall_i;
  assign push    = in_acc && (grp.count != 2'd0);
  assign pop     = out_acc && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      in_hex_q <= 1'b0;
      seen_q   <= 2'd0;
      cp_q     <= 16'h0000;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      sub_q    <= 2'd0;
    end else begin
      mode_q   <= mode_d;
      in_hex_q <= in_hex_d;
      seen_q   <= seen_d;
      cp_q     <= cp_d;
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastSlot) ? '0 : wr_ptr_q + AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastSlot) ? '0 : rd_ptr_q + AW'(1);
        sub_q    <= 2'd0;
      end else if (out_acc) begin
        sub_q <= sub_q + 2'd1;
      end
      if (push && !pop) count_q <= count_q + CW'(1);
      else if (pop && !push) count_q <= count_q - CW'(1);
    end
  end

  // queue payload carries no reset
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= grp;
    end
  end

endmodule

// ----- rtl/jsu_checker.sv -----
// port level checks of the json string unescape unit and their binding
module jsu_checker import jsu_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       byte_valid_o,
  input logic       run_last_o,
  input logic       string_done_o,
  input logic [1:0] outcome_o
);

  // an empty result word only ever ends the string
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !byte_valid_o) |-> (string_done_o && out_byte_o == 8'h00))
    else $error("empty word without string end");

  // outcome only set on the closing word, which is also the last of its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && outcome_o != OUT_ONGOING) |-> (string_done_o && run_last_o))
    else $error("outcome outside the closing word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && string_done_o) |-> (outcome_o != OUT_ONGOING))
    else $error("string end without outcome");

  // nothing follows the end of the string
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && string_done_o) |=> !out_valid_o)
    else $error("word after string end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_byte_o)))
    else $error("stalled output word changed");

endmodule

bind json_string_unescape_unit jsu_checker u_jsu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .out_byte_o    (out_byte_o),
  .byte_valid_o  (byte_valid_o),
  .run_last_o    (run_last_o),
  .string_done_o (string_done_o),
  .outcome_o     (outcome_o)
);
